@@ hw/rtl/ssv_pkg.sv @@
// Shared types, constants and helpers of the snapshot stream validator.
`default_nettype none

package ssv_pkg;

  // Snapshot layout
  localparam int MagicLen  = 12;
  localparam int CountLen  = 8;
  localparam int IdLen     = 32;
  localparam int EntryLen  = 48;
  localparam logic [63:0] CountLimit = 64'd384307168202282324;

  // Result queue depth (holds at least one record plus one status)
  localparam int QueueDepth = 4;

  // Output tdata width: six 64-bit words and a 3-bit status, padded to bytes
  localparam int OutDataW = 392;

  // Parser phases
  typedef enum logic [3:0] {
    PH_MAGIC   = 4'b0001,
    PH_COUNT   = 4'b0010,
    PH_ENTRIES = 4'b0100,
    PH_DRAIN   = 4'b1000
  } phase_t;

  // Running account ID comparison against the previous entry
  typedef enum logic [2:0] {
    CMP_EQUAL   = 3'b001,
    CMP_LESS    = 3'b010,
    CMP_GREATER = 3'b100
  } cmp_t;

  // Final status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_MAGIC = 3'd1,
    ST_COUNT_BIG = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_TRAILING  = 3'd4,
    ST_ORDER     = 3'd5
  } status_t;

  // Result kinds
  localparam logic KindRecord = 1'b0;
  localparam logic KindStatus = 1'b1;

  // One result item
  typedef struct packed {
    logic        kind;
    logic [63:0] word0;
    logic [63:0] word1;
    logic [63:0] word2;
    logic [63:0] word3;
    logic [63:0] balance;
    logic [63:0] nonce;
    logic [2:0]  status;
    logic        last;
  } result_t;

  // Results produced by one input transaction
  typedef struct packed {
    logic rec_valid;
    logic sts_valid;
  } push_t;

  // Magic string, one byte per position
  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h4E;
      4'd1:    b = 8'h55;
      4'd2:    b = 8'h4C;
      4'd3:    b = 8'h4C;
      4'd4:    b = 8'h2D;
      4'd5:    b = 8'h53;
      4'd6:    b = 8'h4E;
      4'd7:    b = 8'h41;
      4'd8:    b = 8'h50;
      4'd9:    b = 8'h2D;
      4'd10:   b = 8'h56;
      4'd11:   b = 8'h31;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ssv_parser.sv @@
// Byte-serial snapshot parser: magic, count, entries, order check, status.
`default_nettype none

module ssv_parser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      data_byte,
  input  wire logic            byte_present,
  input  wire logic            end_of_snapshot,
  output ssv_pkg::push_t       push,
  output ssv_pkg::result_t     rec,
  output ssv_pkg::result_t     sts
);
  import ssv_pkg::*;

  // Control state
  phase_t      phase, phase_next;
  logic [5:0]  pos, pos_next;
  logic        have_prev, have_prev_next;
  cmp_t        cmp, cmp_next;
  status_t     err, err_next;

  // Payload state
  logic [63:0]  count, count_next;
  logic [255:0] cur_id, cur_id_next;
  logic [255:0] prev_id, prev_id_next;
  logic [63:0]  bal_acc, bal_acc_next;
  logic [63:0]  non_acc, non_acc_next;

  logic [4:0]   lane;
  logic [7:0]   prev_byte;
  status_t      final_status;

  // ID byte lane: first byte of each word is most significant
  assign lane      = {pos[4:3], ~pos[2:0]};
  assign prev_byte = prev_id[{lane, 3'b000} +: 8];

  // Next state for one transaction
  always_comb begin
    phase_next     = phase;
    pos_next       = pos;
    have_prev_next = have_prev;
    cmp_next       = cmp;
    err_next       = err;
    count_next     = count;
    cur_id_next    = cur_id;
    prev_id_next   = prev_id;
    bal_acc_next   = bal_acc;
    non_acc_next   = non_acc;
    push           = '0;
    final_status   = ST_OK;

    if (accept && byte_present) begin
      case (phase)
        PH_MAGIC: begin
          if (pos < 6'(MagicLen) && data_byte == magic_byte(pos[3:0])) begin
            if (pos == 6'(MagicLen - 1)) begin
              pos_next   = '0;
              phase_next = PH_COUNT;
            end else begin
              pos_next = pos + 6'd1;
            end
          end else begin
            err_next   = ST_BAD_MAGIC;
            phase_next = PH_DRAIN;
          end
        end
        PH_COUNT: begin
          count_next[{pos[2:0], 3'b000} +: 8] = data_byte;
          if (pos == 6'(CountLen - 1)) begin
            pos_next = '0;
            if (count_next > CountLimit) begin
              err_next   = ST_COUNT_BIG;
              phase_next = PH_DRAIN;
            end else if (count_next == '0) begin
              phase_next = PH_DRAIN;
            end else begin
              phase_next = PH_ENTRIES;
            end
          end else begin
            pos_next = pos + 6'd1;
          end
        end
        PH_ENTRIES: begin
          if (pos < 6'(IdLen)) begin
            // Store the ID byte and advance the byte-serial compare
            cur_id_next[{lane, 3'b000} +: 8] = data_byte;
            if (cmp == CMP_EQUAL) begin
              if (prev_byte < data_byte) begin
                cmp_next = CMP_LESS;
              end else if (prev_byte > data_byte) begin
                cmp_next = CMP_GREATER;
              end
            end
            pos_next = pos + 6'd1;
            if (pos == 6'(IdLen - 1) && have_prev && cmp_next != CMP_LESS) begin
              err_next   = ST_ORDER;
              phase_next = PH_DRAIN;
            end
          end else begin
            if (pos < 6'(IdLen + 8)) begin
              bal_acc_next[{pos[2:0], 3'b000} +: 8] = data_byte;
            end else begin
              non_acc_next[{pos[2:0], 3'b000} +: 8] = data_byte;
            end
            if (pos == 6'(EntryLen - 1)) begin
              // Entry complete: emit record, count down the remaining entries
              push.rec_valid = 1'b1;
              prev_id_next   = cur_id;
              have_prev_next = 1'b1;
              cmp_next       = CMP_EQUAL;
              pos_next       = '0;
              count_next     = count - 64'd1;
              if (count == 64'd1) begin
                phase_next = PH_DRAIN;
              end
            end else begin
              pos_next = pos + 6'd1;
            end
          end
        end
        PH_DRAIN: begin
          if (err == ST_OK) begin
            err_next = ST_TRAILING;
          end
        end
        default: begin
        end
      endcase
    end

    // End marker: report status and start over
    if (accept && end_of_snapshot) begin
      push.sts_valid = 1'b1;
      if (err_next != ST_OK) begin
        final_status = err_next;
      end else if (phase_next == PH_DRAIN) begin
        final_status = ST_OK;
      end else begin
        final_status = ST_TRUNCATED;
      end
      phase_next     = PH_MAGIC;
      pos_next       = '0;
      have_prev_next = 1'b0;
      cmp_next       = CMP_EQUAL;
      err_next       = ST_OK;
    end
  end

  // Result payloads
  always_comb begin
    rec         = '0;
    rec.kind    = KindRecord;
    rec.word0   = cur_id[63:0];
    rec.word1   = cur_id[127:64];
    rec.word2   = cur_id[191:128];
    rec.word3   = cur_id[255:192];
    rec.balance = bal_acc_next;
    rec.nonce   = non_acc_next;

    sts         = '0;
    sts.kind    = KindStatus;
    sts.status  = final_status;
    sts.last    = 1'b1;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_MAGIC;
      pos       <= '0;
      have_prev <= 1'b0;
      cmp       <= CMP_EQUAL;
      err       <= ST_OK;
    end else begin
      phase     <= phase_next;
      pos       <= pos_next;
      have_prev <= have_prev_next;
      cmp       <= cmp_next;
      err       <= err_next;
    end
  end

  // Payload registers: every lane is written before it is used
  always_ff @(posedge clk) begin
    count   <= count_next;
    cur_id  <= cur_id_next;
    prev_id <= prev_id_next;
    bal_acc <= bal_acc_next;
    non_acc <= non_acc_next;
  end

endmodule

`default_nettype wire

@@ hw/rtl/ssv_result_queue.sv @@
// Result queue: takes up to two results per cycle, hands out one per cycle while out_ready is high.
`default_nettype none

module ssv_result_queue #(
  parameter int Depth = ssv_pkg::QueueDepth
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  ssv_pkg::push_t        push,
  input  ssv_pkg::result_t      rec,
  input  ssv_pkg::result_t      sts,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ssv_pkg::result_t      head
);
  import ssv_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  result_t           mem [Depth];
  logic [PtrW-1:0]   wr_ptr, rd_ptr, wr_ptr_inc;
  logic [CntW-1:0]   fill, fill_next;
  logic [1:0]        n_wr;
  logic              pop;
  result_t           first;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
    return r;
  endfunction

  assign wr_ptr_inc = ptr_inc(wr_ptr);
  assign n_wr       = {1'b0, push.rec_valid} + {1'b0, push.sts_valid};
  assign first      = push.rec_valid ? rec : sts;
  assign pop        = out_valid && out_ready;
  assign out_valid  = (fill != '0);
  assign room       = (fill <= CntW'(Depth - 2));
  assign head       = mem[rd_ptr];
  assign fill_next  = fill + CntW'(n_wr) - CntW'(pop);

  // Write the record first, then the status
  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) begin
      mem[wr_ptr] <= first;
    end
    if (push.rec_valid && push.sts_valid) begin
      mem[wr_ptr_inc] <= sts;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (n_wr == 2'd2) begin
        wr_ptr <= ptr_inc(wr_ptr_inc);
      end else if (n_wr == 2'd1) begin
        wr_ptr <= wr_ptr_inc;
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      fill <= fill_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/snapshot_stream_validator.sv @@
// Top level: stream ports around the snapshot parser and its result queue.
// Output: a result is written into the result queue when the transaction that
//   completes it is accepted, and is presented once it reaches the queue head.
// Throughput: one input byte per cycle; tready falls only while the result
//   queue has fewer than two free entries.
// Reset: parser returns to the magic phase and the result queue empties.
`default_nettype none

module snapshot_stream_validator #(
  parameter int QueueDepth = ssv_pkg::QueueDepth
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // data_byte
  input  wire logic                          s_axis_tuser,  // byte_present
  input  wire logic                          s_axis_tlast,  // end_of_snapshot
  // Result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // account_word0, account_word1, account_word2, account_word3, balance,
  // nonce, status, zero padding
  output logic [ssv_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic                               m_axis_tuser,  // result_kind
  output logic                               m_axis_tlast   // last
);
  import ssv_pkg::*;

  push_t   push;
  result_t rec, sts, head;
  logic    room;
  logic    accept;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  ssv_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .data_byte       (s_axis_tdata),
    .byte_present    (s_axis_tuser),
    .end_of_snapshot (s_axis_tlast),
    .push            (push),
    .rec             (rec),
    .sts             (sts)
  );

  ssv_result_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .rec       (rec),
    .sts       (sts),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .head      (head)
  );

  // Pack the head result onto the master side
  assign m_axis_tdata = {5'b00000, head.status, head.nonce, head.balance,
                         head.word3, head.word2, head.word1, head.word0};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

`default_nettype wire
